/* rtl/core/smaa_pkg.sv */
// ----------------------------------------------------------------------------
// smaa_pkg
// Shared widths, reset values and control types of the square matrix
// add / subtract / multiply block.
// ----------------------------------------------------------------------------
package smaa_pkg;

    // configuration register
    localparam int SIZE_W = 4;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // result fields
    localparam int ROW_W  = 3;
    localparam int COL_W  = 3;
    localparam int SUM_W  = 17;
    localparam int DIFF_W = 17;
    localparam int PROD_W = 35;

    localparam int OUT_FIELDS_W = ROW_W + COL_W + SUM_W + DIFF_W + PROD_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_W - OUT_FIELDS_W;

    // bit offsets of the result fields inside the result tdata
    localparam int ROW_LSB  = 0;
    localparam int COL_LSB  = ROW_LSB + ROW_W;
    localparam int SUM_LSB  = COL_LSB + COL_W;
    localparam int DIFF_LSB = SUM_LSB + SUM_W;
    localparam int PROD_LSB = DIFF_LSB + DIFF_W;

    // sequencer to multiply-accumulate pipe
    typedef struct packed {
        logic issue;   // a read pair is presented to the stores this cycle
        logic first;   // first term of a dot product
        logic last;    // last term of a dot product
        logic take_a;  // this A read is the element at the result position
        logic take_b;  // this B read is the element at the result position
        logic clear;   // result handed off, drop the done flag
    } mac_ctrl_t;

endpackage

/* rtl/core/smaa_ram.sv */
// ----------------------------------------------------------------------------
// smaa_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. No reset on the contents.
// ----------------------------------------------------------------------------
module smaa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/smaa_mac.sv */
// ----------------------------------------------------------------------------
// smaa_mac
// Multiply-accumulate pipe behind the two element stores. Stage 1 holds the
// store read data, stage 2 the registered product, then the accumulator.
// Also captures A and B at the result position for the sum and difference.
// ----------------------------------------------------------------------------
module smaa_mac #(
    parameter int ELEM_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  smaa_pkg::mac_ctrl_t           ctrl,
    input  logic signed [ELEM_BITS-1:0]   a_data,
    input  logic signed [ELEM_BITS-1:0]   b_data,
    output logic [smaa_pkg::PROD_W-1:0]   acc,
    output logic signed [ELEM_BITS-1:0]   a_cap,
    output logic signed [ELEM_BITS-1:0]   b_cap,
    output logic                          done
);
    import smaa_pkg::*;

    localparam int PFULL_W = 2 * ELEM_BITS;
    localparam int PEXT_W  = (PFULL_W > PROD_W) ? PFULL_W : PROD_W;

    // stage 1: read data valid
    logic s1_valid_reg, s1_first_reg, s1_last_reg, s1_take_a_reg, s1_take_b_reg;
    // stage 2: product valid
    logic s2_valid_reg, s2_first_reg, s2_last_reg;

    logic signed [PFULL_W-1:0] prod_full;
    logic signed [PEXT_W-1:0]  prod_ext;
    logic [PROD_W-1:0]         prod_reg;
    logic [PROD_W-1:0]         acc_reg;
    logic signed [ELEM_BITS-1:0] a_cap_reg, b_cap_reg;
    logic                      done_reg;

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s1_first_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s1_take_a_reg <= 1'b0;
            s1_take_b_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_first_reg  <= 1'b0;
            s2_last_reg   <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            s1_valid_reg  <= ctrl.issue;
            s1_first_reg  <= ctrl.first;
            s1_last_reg   <= ctrl.last;
            s1_take_a_reg <= ctrl.issue & ctrl.take_a;
            s1_take_b_reg <= ctrl.issue & ctrl.take_b;
            s2_valid_reg  <= s1_valid_reg;
            s2_first_reg  <= s1_first_reg;
            s2_last_reg   <= s1_last_reg;
            if (ctrl.clear) begin
                done_reg <= 1'b0;
            end else if (s2_valid_reg && s2_last_reg) begin
                done_reg <= 1'b1;
            end
        end
    end

    // multiply, sign-extend, keep the low product bits
    assign prod_full = a_data * b_data;
    assign prod_ext  = PEXT_W'(prod_full);

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            prod_reg <= prod_ext[PROD_W-1:0];
        end
        if (s1_take_a_reg) begin
            a_cap_reg <= a_data;
        end
        if (s1_take_b_reg) begin
            b_cap_reg <= b_data;
        end
        if (s2_valid_reg) begin
            acc_reg <= (s2_first_reg ? '0 : acc_reg) + prod_reg;
        end
    end

    assign acc   = acc_reg;
    assign a_cap = a_cap_reg;
    assign b_cap = b_cap_reg;
    assign done  = done_reg;

endmodule

/* rtl/core/square_matrix_add_sub_multiply_top.sv */
// ----------------------------------------------------------------------------
// square_matrix_add_sub_multiply_top
// Loads two n-by-n signed matrices, then streams A+B, A-B and A*B per element.
// ----------------------------------------------------------------------------
// Usage: each input beat carries A[i][j] and B[i][j] in row-major order; n is
// matrix_size, where 0 counts as 1 and values above MAX_DIM count as MAX_DIM.
// Loading takes one beat per cycle. After the n*n-th beat, input is held off
// while n*n result beats are produced in row-major order; for each result,
// row i of A and column j of B are read through the single read port of each
// element store, then the multiply-accumulate pipe drains and the result
// reaches the output register. The final result may still wait in the output
// register while loading of the next matrices starts. A write of matrix_size
// restarts loading; write it only while the block is idle. The stores need
// no clearing after reset.
// ----------------------------------------------------------------------------
module square_matrix_add_sub_multiply_top #(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 16,
    localparam int IN_W = ((2 * ELEM_BITS + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration: matrix_size
    input  logic                        cfg_wr_en,
    input  logic [smaa_pkg::SIZE_W-1:0] cfg_wr_data,
    // input beats
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [IN_W-1:0]             s_tdata,  // a_element, b_element, zero pad
    // result beats
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [smaa_pkg::OUT_W-1:0]  m_tdata,  // row_index, col_index, sum_value,
                                                  // diff_value, product_value, zero pad
    output logic                        m_tlast   // last_result
);
    import smaa_pkg::*;

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int SEXT_W = (ELEM_BITS + 1 > SUM_W) ? ELEM_BITS + 1 : SUM_W;
    localparam logic [SIZE_W:0] MAX_DIM_CMP = (SIZE_W + 1)'(MAX_DIM);
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_DIM - 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_FINISH
    } state_t;

    state_t            state_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [IDX_W-1:0]  ld_row_reg, ld_col_reg;
    logic [IDX_W-1:0]  i_reg, j_reg, k_reg;
    logic              out_valid_reg, out_last_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic [IDX_W-1:0]  last_idx;
    logic [SIZE_W-1:0] size_m1;
    logic              in_beat, emit;
    logic              a_wr_unused;

    mac_ctrl_t         mac_ctrl;
    logic signed [ELEM_BITS-1:0] a_rd, b_rd, a_cap, b_cap;
    logic [PROD_W-1:0] acc;
    logic              mac_done;

    logic signed [SEXT_W-1:0] sum_ext, diff_ext;

    // highest row / column index in use
    assign size_m1 = size_reg - 1'b1;
    always_comb begin
        if (size_reg == '0) begin
            last_idx = '0;
        end else if ({1'b0, size_reg} > MAX_DIM_CMP) begin
            last_idx = MAX_IDX;
        end else begin
            last_idx = IDX_W'(size_m1);
        end
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign in_beat  = s_tvalid && s_tready;
    assign emit     = (state_reg == ST_FINISH) && mac_done && (!out_valid_reg || m_tready);
    assign a_wr_unused = 1'b0;

    // element stores: write at {row, col} while loading, read row i of A and
    // column j of B while issuing
    smaa_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_store_a (
        .aclk    (aclk),
        .wr_en   (in_beat),
        .wr_addr ({ld_row_reg, ld_col_reg}),
        .wr_data (s_tdata[ELEM_BITS-1:0]),
        .rd_en   (mac_ctrl.issue),
        .rd_addr ({i_reg, k_reg}),
        .rd_data (a_rd)
    );

    smaa_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_store_b (
        .aclk    (aclk),
        .wr_en   (in_beat),
        .wr_addr ({ld_row_reg, ld_col_reg}),
        .wr_data (s_tdata[2*ELEM_BITS-1:ELEM_BITS]),
        .rd_en   (mac_ctrl.issue),
        .rd_addr ({k_reg, j_reg}),
        .rd_data (b_rd)
    );

    // control toward the multiply-accumulate pipe
    always_comb begin
        mac_ctrl.issue  = (state_reg == ST_ISSUE);
        mac_ctrl.first  = (k_reg == '0);
        mac_ctrl.last   = (k_reg == last_idx);
        mac_ctrl.take_a = (k_reg == j_reg);
        mac_ctrl.take_b = (k_reg == i_reg);
        mac_ctrl.clear  = emit | a_wr_unused;
    end

    smaa_mac #(.ELEM_BITS(ELEM_BITS)) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .a_data  (a_rd),
        .b_data  (b_rd),
        .acc     (acc),
        .a_cap   (a_cap),
        .b_cap   (b_cap),
        .done    (mac_done)
    );

    // element-wise sum and difference at the result position
    assign sum_ext  = SEXT_W'(a_cap) + SEXT_W'(b_cap);
    assign diff_ext = SEXT_W'(a_cap) - SEXT_W'(b_cap);

    // sequencer, load counters and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            size_reg      <= SIZE_RESET;
            ld_row_reg    <= '0;
            ld_col_reg    <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end else begin
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                size_reg   <= cfg_wr_data;
                ld_row_reg <= '0;
                ld_col_reg <= '0;
            end else begin
                case (state_reg)
                    ST_LOAD: begin
                        if (in_beat) begin
                            if (ld_col_reg == last_idx) begin
                                ld_col_reg <= '0;
                                if (ld_row_reg == last_idx) begin
                                    ld_row_reg <= '0;
                                    i_reg      <= '0;
                                    j_reg      <= '0;
                                    k_reg      <= '0;
                                    state_reg  <= ST_ISSUE;
                                end else begin
                                    ld_row_reg <= ld_row_reg + 1'b1;
                                end
                            end else begin
                                ld_col_reg <= ld_col_reg + 1'b1;
                            end
                        end
                    end
                    ST_ISSUE: begin
                        if (k_reg == last_idx) begin
                            k_reg     <= '0;
                            state_reg <= ST_FINISH;
                        end else begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                    ST_FINISH: begin
                        if (emit) begin
                            out_last_reg <= (i_reg == last_idx) && (j_reg == last_idx);
                            if (j_reg == last_idx) begin
                                j_reg <= '0;
                                if (i_reg == last_idx) begin
                                    i_reg     <= '0;
                                    state_reg <= ST_LOAD;
                                end else begin
                                    i_reg     <= i_reg + 1'b1;
                                    state_reg <= ST_ISSUE;
                                end
                            end else begin
                                j_reg     <= j_reg + 1'b1;
                                state_reg <= ST_ISSUE;
                            end
                        end
                    end
                    default: begin
                        state_reg <= ST_LOAD;
                    end
                endcase
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_data_reg <= {{OUT_PAD_W{1'b0}},
                             acc,
                             diff_ext[DIFF_W-1:0],
                             sum_ext[SUM_W-1:0],
                             COL_W'(j_reg),
                             ROW_W'(i_reg)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/core/smaa_checker.sv */
// ----------------------------------------------------------------------------
// smaa_checker
// Port-level checks of the matrix block: held results, the load / compute
// handoff and the position of the final result.
// ----------------------------------------------------------------------------
module smaa_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [smaa_pkg::OUT_W-1:0] m_tdata,
    input logic                       m_tlast
);
    import smaa_pkg::*;

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // a new result only comes out of the compute phase
    a_rise_from_compute: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while loading");

    // while loading, only the final result of the previous matrix may wait
    a_wait_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tlast)
        else $error("non-final result pending during load");

    // the final result sits on the diagonal
    a_last_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |->
            m_tdata[ROW_LSB +: ROW_W] == m_tdata[COL_LSB +: COL_W])
        else $error("final result off the diagonal");

endmodule

bind square_matrix_add_sub_multiply_top smaa_checker u_smaa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
